// File: sv/isqrt_pkg.sv
`timescale 1ns / 1ps

package isqrt_pkg;

	// Default root width; the operand is twice as wide
	localparam int ROOT_WIDTH_DEF = 64;

	// Width of the fixed operand and result ports
	localparam int PORT_WIDTH = 64;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;     // take a new operand, clear root and remainder
		logic step;     // settle one root bit
		logic capture;  // move the root into the output register
	} cmd_t;

endpackage

// File: sv/integer_square_root_top.sv
// Integer square root of a 2*ROOT_WIDTH-bit unsigned operand, one root bit per cycle.
// Each item is loaded while idle and then stepped through its root bits; in_stall is high outside idle.
// A finished result waits in an output register while the next item is taken.
// Reset (arst_n low, asynchronous) empties the controller; data registers are not reset.
`timescale 1ns / 1ps

module integer_square_root_top #(
	parameter int ROOT_WIDTH = isqrt_pkg::ROOT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [isqrt_pkg::PORT_WIDTH-1:0]  value_high,
	input  logic [isqrt_pkg::PORT_WIDTH-1:0]  value_low,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [isqrt_pkg::PORT_WIDTH-1:0]  root
);

	isqrt_pkg::cmd_t cmd;

	// Sequencer
	isqrt_ctrl #(
		.ROOT_WIDTH(ROOT_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Root and remainder registers
	isqrt_dp #(
		.ROOT_WIDTH(ROOT_WIDTH)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.value_high (value_high),
		.value_low  (value_low),
		.root       (root)
	);

endmodule

// File: sv/isqrt_ctrl.sv
`timescale 1ns / 1ps

module isqrt_ctrl #(
	parameter int ROOT_WIDTH = isqrt_pkg::ROOT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output isqrt_pkg::cmd_t   cmd
);

	localparam int CW = $clog2(ROOT_WIDTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;
	logic          last;

	// Output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign last     = (cnt_q == '0);
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd.load    = in_valid && (state_q == S_IDLE);
		cmd.step    = (state_q == S_RUN);
		cmd.capture = ((state_q == S_RUN) && last && out_free) ||
		              ((state_q == S_HOLD) && out_free);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) state_d = S_RUN;
			end
			S_RUN: begin
				if (last) state_d = out_free ? S_IDLE : S_HOLD;
			end
			S_HOLD: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, bit counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= CW'(ROOT_WIDTH - 1);
			end else if (cmd.step && !last) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A capture never overwrites a result still waiting
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || !out_stall))
		else $error("capture over a pending result");

	// A new item starts a full bit sweep
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_RUN) && (cnt_q == CW'(ROOT_WIDTH - 1)))
		else $error("load did not start the sweep");

	// Holding only happens behind a waiting result
	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> out_valid_q)
		else $error("hold state without pending result");

endmodule

// File: sv/isqrt_dp.sv
`timescale 1ns / 1ps

module isqrt_dp #(
	parameter int ROOT_WIDTH = isqrt_pkg::ROOT_WIDTH_DEF
) (
	input  logic                              clk,
	input  isqrt_pkg::cmd_t                   cmd,
	input  logic [isqrt_pkg::PORT_WIDTH-1:0]  value_high,
	input  logic [isqrt_pkg::PORT_WIDTH-1:0]  value_low,
	output logic [isqrt_pkg::PORT_WIDTH-1:0]  root
);

	localparam int RW = ROOT_WIDTH;
	localparam int OW = 2 * ROOT_WIDTH;

	logic [2*isqrt_pkg::PORT_WIDTH-1:0] operand;
	logic [OW-1:0]   op_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [RW-1:0]   out_root_q;
	logic [RW+2:0]   shifted;
	logic [RW+2:0]   trial_sub;
	logic [RW+2:0]   diff;
	logic            keep;
	logic [RW:0]     rem_d;
	logic [RW-1:0]   root_d;

	// Bits above twice the root width are dropped
	assign operand = {value_high, value_low};

	// One restoring step: bring in two operand bits, try root*4+1
	always_comb begin
		shifted   = {rem_q, op_q[OW-1 -: 2]};
		trial_sub = {1'b0, root_q, 2'b01};
		diff      = shifted - trial_sub;
		keep      = (shifted >= trial_sub);
		rem_d     = keep ? diff[RW:0] : shifted[RW:0];
		root_d    = {root_q[RW-2:0], keep};
	end

	// Working registers and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operand[OW-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.step) begin
			op_q   <= {op_q[OW-3:0], 2'b00};
			rem_q  <= rem_d;
			root_q <= root_d;
		end
		if (cmd.capture) begin
			out_root_q <= cmd.step ? root_d : root_q;
		end
	end

	assign root = isqrt_pkg::PORT_WIDTH'(out_root_q);

endmodule

// File: tb/tb_integer_square_root_top.sv
`timescale 1ns / 1ps

module tb_integer_square_root_top;

	localparam int ROOT_W      = isqrt_pkg::ROOT_WIDTH_DEF;
	localparam int PW          = isqrt_pkg::PORT_WIDTH;
	localparam int RANDOM_N    = 1230;
	localparam int CALM_TAIL   = 150;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [127:0] operand;
		bit           drain_first;  // wait for all roots before offering this item
	} operand_item_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [PW-1:0] value_high = '0;
	logic [PW-1:0] value_low = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [PW-1:0] root;

	operand_item_t operand_q[$];
	logic [63:0]   root_expect_q[$];
	operand_item_t next_item;
	logic [63:0]   want_root;

	int  sent_n = 0;
	int  roots_n = 0;
	int  errors = 0;
	int  directed_n = 0;
	int  send_gap = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	bit  hold_done = 0;
	int  cycles = 0;

	integer_square_root_top #(
		.ROOT_WIDTH(ROOT_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value_high(value_high),
		.value_low (value_low),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root      (root)
	);

	// Floor square root, one trial bit per step from the top down
	function automatic logic [63:0] floor_sqrt(input logic [127:0] operand);
		logic [127:0] x;
		logic [127:0] sq;
		logic [63:0]  r;
		logic [63:0]  cand;
		x = operand;
		if (2 * ROOT_W < 128) begin
			x = x & ((128'd1 << (2 * ROOT_W)) - 128'd1);
		end
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			sq = {64'd0, cand} * {64'd0, cand};
			if (sq <= x) begin
				r = cand;
			end
		end
		return r;
	endfunction

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// No idling in the tail, in every fourth window of 100 items, or during the long hold
	function automatic bit idling_allowed();
		return operand_q.size() >= CALM_TAIL && ((sent_n / 100) % 4) != 3 && hold_left == 0;
	endfunction

	task automatic queue_operand(input logic [127:0] v, input bit drain);
		operand_item_t it;
		it.operand = v;
		it.drain_first = drain;
		operand_q.push_back(it);
	endtask

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d roots still owed", cycles,
				root_expect_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// Driver: offer queued operands, record expected roots on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value_high <= '0;
			value_low <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				root_expect_q.push_back(floor_sqrt({value_high, value_low}));
				sent_n++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (operand_q.size() > 0 &&
						!(operand_q[0].drain_first && root_expect_q.size() > 0)) begin
					next_item = operand_q.pop_front();
					value_high <= next_item.operand[127:64];
					value_low <= next_item.operand[63:0];
					in_valid <= 1'b1;
					if (idling_allowed() && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(1, 15);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random bursts, and one long hold once 50 roots have been checked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			stall_left = 0;
		end else begin
			if (!hold_done && roots_n >= 50) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted root with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (root_expect_q.size() == 0) begin
				if (errors < 10) begin
					$display("Unexpected root %h at cycle %0d", root, cycles);
				end
				errors++;
			end else begin
				want_root = root_expect_q.pop_front();
				roots_n++;
				if (root !== want_root) begin
					if (errors < 10) begin
						$display("Root mismatch #%0d: expected %h, got %h", roots_n,
							want_root, root);
					end
					errors++;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [127:0] v;
		logic [127:0] sq;
		logic [63:0]  k;
		int           sel;
		int           total_n;

		// Directed: extremes, squares and their neighbors, bit patterns
		queue_operand(128'd0, 0);
		queue_operand(128'd1, 0);
		queue_operand(128'd2, 0);
		queue_operand(128'd3, 0);
		queue_operand(128'd4, 0);
		queue_operand(128'd8, 0);
		queue_operand(128'd9, 0);
		queue_operand(128'd15, 0);
		queue_operand(128'd16, 0);
		queue_operand({64'd0, {64{1'b1}}}, 0);
		queue_operand({64'd1, 64'd0}, 0);
		sq = {64'd0, {64{1'b1}}} * {64'd0, {64{1'b1}}};
		queue_operand(sq, 0);
		queue_operand(sq - 128'd1, 0);
		queue_operand(sq + 128'd1, 0);
		queue_operand({128{1'b1}}, 0);
		queue_operand({128{1'b1}} - 128'd1, 0);
		queue_operand(128'd1 << 127, 0);
		queue_operand(128'd1 << 126, 0);
		queue_operand((128'd1 << 126) - 128'd1, 0);
		queue_operand({{64{1'b1}}, 64'd0}, 0);
		queue_operand({64{2'b10}}, 0);
		queue_operand({64{2'b01}}, 0);
		directed_n = operand_q.size();

		// Random: full range, near squares, random magnitudes, near the top
		for (int i = 0; i < RANDOM_N; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				v = rand128();
			end else if (sel < 65) begin
				k = {$urandom, $urandom} >> $urandom_range(0, 63);
				v = {64'd0, k} * {64'd0, k};
				case ($urandom_range(0, 2))
					0: v = v - 128'd1;
					1: v = v + 128'd1;
					default: ;
				endcase
			end else if (sel < 85) begin
				v = rand128() >> $urandom_range(0, 127);
			end else begin
				v = ~(rand128() >> $urandom_range(96, 127));
			end
			queue_operand(v, i == 400 || i == 900);
		end
		total_n = operand_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Run until every queued operand has had its root checked
		do begin
			@(posedge clk);
		end while (roots_n < total_n);
		repeat (150) @(posedge clk);

		$display("%0d operands (%0d directed: zero, one, squares +/-1, all ones, patterns),",
			sent_n, directed_n);
		$display("%0d roots checked with random gaps, a %0d-cycle output hold, two drains",
			roots_n, HOLD_CYCLES);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors", errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/isqrt_pkg.sv
sv/isqrt_ctrl.sv
sv/isqrt_dp.sv
sv/integer_square_root_top.sv
tb/tb_integer_square_root_top.sv
